// File: src/qsort_pkg.sv
// ----------------------------------------------------------------------------
// qsort_pkg
// Shared payload types for the quicksort batch sorter.
// ----------------------------------------------------------------------------
package qsort_pkg;

  typedef struct packed {
    logic signed [31:0] value;
    logic               last;
  } qs_in_t;

  typedef struct packed {
    logic signed [31:0] sorted_value;
    logic               final_res;
    logic               dropped;
  } qs_out_t;

endpackage

// File: src/quicksort_batch_sorter.sv
// ----------------------------------------------------------------------------
// quicksort_batch_sorter
// Batch sorter: collect values, quicksort in place, stream ascending.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall/in_data carry one value per transaction. Values are
//   written to the store as they arrive, one per cycle. A transaction with
//   last set closes the batch; values past DEPTH are dropped and every
//   result of that batch carries dropped.
//   After last, in_stall stays high while the block sorts and drains. Each
//   range is popped, its pivot read and its subranges pushed; each element
//   compared either moves below the pivot or is swapped to the top, which
//   takes one extra write on the single store port. Sorted input is the
//   worst case. The sorted values then leave on out_valid/out_data, one
//   value per transaction, final_res on the last one. out_stall holds the
//   output register and its payload; the block waits.
//   Reset clears the counts, flags and state; store contents are left as-is.
// ----------------------------------------------------------------------------
module quicksort_batch_sorter
  import qsort_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  qs_in_t  in_data,
  output logic    out_valid,
  input  logic    out_stall,
  output qs_out_t out_data
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [3:0] {
    S_LOAD, S_POP, S_POPW, S_RDP, S_RDC, S_CMP, S_WA, S_WB, S_WC, S_RDN,
    S_PUSH2, S_OUTRD, S_OUTW
  } st_t;

  st_t st_r;
  logic [CW-1:0] cnt_r, lo_r, hi_r, end_r, piv_r, cur_r, sp_r, k_r;
  logic          ovf_r;
  logic [31:0]   pv_r, cv_r;
  logic          le_r;   // swap with pivot, else swap with hi-1
  logic          out_valid_r;
  qs_out_t       out_r;

  // store port
  logic          m_we;
  logic [AW-1:0] m_addr;
  logic [31:0]   m_wd, m_rd;
  // stack port
  logic          s_we;
  logic [AW-1:0] s_addr;
  logic [2*CW-1:0] s_wd, s_rd;

  qsort_mem #(.W(32), .N(DEPTH)) u_store (
    .clk(clk), .we(m_we), .addr(m_addr), .wdata(m_wd), .rdata(m_rd));
  qsort_mem #(.W(2*CW), .N(DEPTH)) u_stack (
    .clk(clk), .we(s_we), .addr(s_addr), .wdata(s_wd), .rdata(s_rd));

  logic accept;
  assign in_stall  = (st_r != S_LOAD);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  logic [CW-1:0] hi_m1, piv_p1;
  assign hi_m1  = hi_r - CW'(1);
  assign piv_p1 = piv_r + CW'(1);

  // memory port steering
  always_comb begin
    m_we = 1'b0; m_addr = '0; m_wd = '0;
    s_we = 1'b0; s_addr = '0; s_wd = '0;
    case (st_r)
      S_LOAD: begin
        m_we = accept && (cnt_r < CW'(DEPTH));
        m_addr = cnt_r[AW-1:0];
        m_wd = in_data.value;
      end
      S_POP:   s_addr = AW'(sp_r - CW'(1));
      S_RDP:   m_addr = piv_r[AW-1:0];
      S_RDC:   m_addr = cur_r[AW-1:0];
      S_RDN:   m_addr = cur_r[AW-1:0];
      S_WA: begin
        // le: pivot value to cur; else: read the value at hi-1
        if (le_r) begin
          m_we = 1'b1; m_addr = cur_r[AW-1:0]; m_wd = pv_r;
        end else begin
          m_addr = hi_m1[AW-1:0];
        end
      end
      S_WB: begin
        m_we = 1'b1; m_wd = cv_r;
        if (le_r) begin
          m_addr = piv_r[AW-1:0];
        end else begin
          m_addr = hi_m1[AW-1:0];
        end
      end
      S_WC: begin
        // old hi-1 value into cur
        m_we = 1'b1; m_addr = cur_r[AW-1:0]; m_wd = cv_r;
      end
      S_PUSH2: begin
        s_we = (piv_r - lo_r) > CW'(1);
        s_addr = sp_r[AW-1:0]; s_wd = {lo_r, piv_r};
      end
      S_OUTRD: m_addr = k_r[AW-1:0];
      default: ;
    endcase
    if (st_r == S_CMP && cur_r >= hi_r) begin
      // partition done: push right range if it needs sorting
      s_we = (end_r - piv_p1) > CW'(1);
      s_addr = sp_r[AW-1:0]; s_wd = {piv_p1, end_r};
    end
    if (st_r == S_LOAD && accept && in_data.last) begin
      s_we = 1'b1; s_addr = '0;
      s_wd = {CW'(0), (cnt_r < CW'(DEPTH)) ? cnt_r + CW'(1) : cnt_r};
    end
  end

  // le swaps [cur]<->[piv] in S_WA/S_WB; else swaps [cur]<->[hi-1]: read
  // hi-1 in S_WA, write it in S_WB, write cur in S_WC. The cursor is then
  // read again in S_RDN before the next compare.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_LOAD; cnt_r <= '0; ovf_r <= 1'b0; sp_r <= '0;
      out_valid_r <= 1'b0; k_r <= '0;
    end else begin
      unique case (st_r)
        S_LOAD: if (accept) begin
          if (cnt_r < CW'(DEPTH)) cnt_r <= cnt_r + CW'(1);
          else ovf_r <= 1'b1;
          if (in_data.last) begin
            sp_r <= CW'(1);
            st_r <= S_POP;
          end
        end
        S_POP: begin
          if (sp_r == '0 || cnt_r < CW'(2)) begin
            k_r <= '0; st_r <= S_OUTRD;
          end else begin
            sp_r <= sp_r - CW'(1); st_r <= S_POPW;
          end
        end
        S_POPW: begin
          lo_r <= s_rd[2*CW-1:CW]; hi_r <= s_rd[CW-1:0]; end_r <= s_rd[CW-1:0];
          piv_r <= s_rd[2*CW-1:CW]; cur_r <= s_rd[2*CW-1:CW] + CW'(1);
          st_r <= S_RDP;
        end
        S_RDP: st_r <= S_RDC;
        S_RDC: begin pv_r <= m_rd; st_r <= S_CMP; end
        S_CMP: begin
          if (cur_r >= hi_r) begin
            if ((end_r - piv_p1) > CW'(1)) sp_r <= sp_r + CW'(1);
            st_r <= S_PUSH2;
          end else begin
            cv_r <= m_rd;
            le_r <= ($signed(m_rd) <= $signed(pv_r));
            st_r <= S_WA;
          end
        end
        S_WA: st_r <= S_WB;
        S_WB: begin
          if (le_r) begin
            piv_r <= cur_r; cur_r <= cur_r + CW'(1);
            // pivot value unchanged, now at cur
            st_r <= S_RDN;
          end else begin
            // hold the old hi-1 value for the cur write
            hi_r <= hi_m1;
            cv_r <= m_rd;
            st_r <= S_WC;
          end
        end
        S_WC: st_r <= S_RDN;
        S_RDN: st_r <= S_CMP;
        S_PUSH2: begin
          if ((piv_r - lo_r) > CW'(1)) sp_r <= sp_r + CW'(1);
          st_r <= S_POP;
        end
        S_OUTRD: if (!out_valid_r || !out_stall) begin
          st_r <= S_OUTW;
        end
        S_OUTW: begin
          out_valid_r <= 1'b1;
          out_r.sorted_value <= m_rd;
          out_r.final_res <= (k_r + CW'(1) == cnt_r);
          out_r.dropped <= ovf_r;
          if (k_r + CW'(1) == cnt_r) begin
            cnt_r <= '0; ovf_r <= 1'b0; st_r <= S_LOAD;
          end else begin
            k_r <= k_r + CW'(1); st_r <= S_OUTRD;
          end
        end
        default: st_r <= S_LOAD;
      endcase
      if (out_valid_r && !out_stall && st_r != S_OUTW) out_valid_r <= 1'b0;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("output changed under stall");
  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH)) else $error("count overflow");
  assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_CMP && cur_r < hi_r |-> piv_r < cur_r)
    else $error("pivot not below cursor");
endmodule

// File: src/qsort_mem.sv
// ----------------------------------------------------------------------------
// qsort_mem
// Single-port synchronous memory, registered read.
// ----------------------------------------------------------------------------
module qsort_mem #(
  parameter int W = 32,
  parameter int N = 64
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(N)-1:0] addr,
  input  logic [W-1:0]         wdata,
  output logic [W-1:0]         rdata
);
  logic [W-1:0] mem [N];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
